// File: sv/est_pkg.sv
// shared types and constants for the enable set table
package est_pkg;

    localparam int CFG_W    = 5;
    localparam int STATUS_W = 3;
    localparam int SLOT_W   = 4;
    localparam int COUNT_W  = 5;
    localparam int RES_W    = STATUS_W + SLOT_W + COUNT_W;
    localparam int OUT_W    = ((RES_W + 7) / 8) * 8;

    localparam logic OP_ENABLE  = 1'b0;
    localparam logic OP_DISABLE = 1'b1;

    typedef enum logic [STATUS_W-1:0] {
        ST_ADDED     = 3'd0,
        ST_PRESENT   = 3'd1,
        ST_REMOVED   = 3'd2,
        ST_NOT_FOUND = 3'd3,
        ST_FULL      = 3'd4
    } status_t;

endpackage

// File: sv/est_ram.sv
// generic single-write, single-read ram with registered read data
module est_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                                  clk,
    input  logic                                  we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                      wdata,
    input  logic                                  re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                      rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: sv/enable_set_table.sv
// enable set table: keeps nonzero handles in fixed slots held in a ram
//
// input channel s_axis: one beat per operation, tuser is the operation
// (0 enable, 1 disable), tdata is the handle. the handle is looked up
// in the first active_slots slots; enable inserts it into the lowest
// empty slot unless present, disable clears the matching slot.
// output channel m_axis: one beat per operation carrying status, slot
// and the number of occupied slots after the operation.
// cfg_we / cfg_wdata write active_slots; write only while idle.
// each item runs through the scan, one read a cycle over the slot ram
// with its registered read data, then a write-back state and the output
// load before the next accept; the scan ends early on a hit. a zero
// handle, or active_slots of zero, skips the scan.
// reset clears every slot (per-slot valid bits), the count and sets
// active_slots to the table depth; no clearing pass is needed.
// the result sits in an output register; while it is stalled the next
// beat is accepted and worked on, and waits only for its own result load.
module enable_set_table #(
    parameter int SLOTS       = 16,
    parameter int HANDLE_BITS = 32
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_we,
    input  logic [est_pkg::CFG_W-1:0]            cfg_wdata,
    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    // handle
    input  logic [((HANDLE_BITS + 7) / 8) * 8-1:0] s_axis_tdata,
    // func
    input  logic                                 s_axis_tuser,
    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    // status, slot, entry_count, zero pad
    output logic [est_pkg::OUT_W-1:0]            m_axis_tdata
);

    localparam int AW   = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int LW   = $clog2(SLOTS + 1);
    localparam int AS_W = (LW > est_pkg::CFG_W) ? LW : est_pkg::CFG_W;
    localparam int PAD_W = est_pkg::OUT_W - est_pkg::RES_W;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_WRITE,
        S_OUT
    } state_t;

    state_t                      state_reg;
    state_t                      state_next;
    logic [AS_W-1:0]             active_reg;
    logic                        func_reg;
    logic [HANDLE_BITS-1:0]      handle_reg;
    logic                        zero_reg;
    logic [LW-1:0]               lim_reg;
    logic [LW-1:0]               lim_next;
    logic [LW-1:0]               issue_reg;
    logic                        pending_reg;
    logic [AW-1:0]               pend_idx_reg;
    logic                        vld_q_reg;
    logic                        hit_reg;
    logic [AW-1:0]               hit_idx_reg;
    logic                        empty_found_reg;
    logic [AW-1:0]               empty_idx_reg;
    logic [LW-1:0]               count_reg;
    logic [SLOTS-1:0]            valid_reg;
    est_pkg::status_t            res_status_reg;
    logic [est_pkg::SLOT_W-1:0]  res_slot_reg;
    logic                        out_valid_reg;
    logic [est_pkg::OUT_W-1:0]   out_data_reg;

    logic                        in_accept;
    logic                        issue_go;
    logic [HANDLE_BITS-1:0]      ram_rdata;
    logic [HANDLE_BITS-1:0]      key_eff;
    logic                        match;
    logic                        last;
    logic                        ins;
    logic                        rem;
    logic                        out_free;
    logic [HANDLE_BITS-1:0]      in_handle;

    assign in_handle = s_axis_tdata[HANDLE_BITS-1:0];
    assign in_accept = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = (state_reg == S_IDLE);
    assign lim_next = (32'(active_reg) > SLOTS) ? LW'(SLOTS) : LW'(active_reg);
    assign issue_go = (state_reg == S_SCAN) && (issue_reg != lim_reg);
    assign key_eff  = vld_q_reg ? ram_rdata : '0;
    assign match    = pending_reg && (key_eff == handle_reg);
    assign last     = pending_reg && ((LW'(pend_idx_reg) + LW'(1)) == lim_reg);
    assign ins      = !zero_reg && (func_reg == est_pkg::OP_ENABLE) && !hit_reg
                      && empty_found_reg;
    assign rem      = !zero_reg && (func_reg == est_pkg::OP_DISABLE) && hit_reg;
    assign out_free = !out_valid_reg || m_axis_tready;

    est_ram #(
        .WIDTH (HANDLE_BITS),
        .DEPTH (SLOTS)
    ) u_keys (
        .clk   (clk),
        .we    ((state_reg == S_WRITE) && ins),
        .waddr (empty_idx_reg),
        .wdata (handle_reg),
        .re    (issue_go),
        .raddr (issue_reg[AW-1:0]),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_accept)
                begin
                    state_next = ((in_handle == '0) || (lim_next == '0)) ? S_WRITE : S_SCAN;
                end
            end
            S_SCAN:
            begin
                if (match || last)
                begin
                    state_next = S_WRITE;
                end
            end
            S_WRITE:
            begin
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            active_reg      <= AS_W'(SLOTS);
            count_reg       <= '0;
            valid_reg       <= '0;
            out_valid_reg   <= 1'b0;
            pending_reg     <= 1'b0;
            hit_reg         <= 1'b0;
            empty_found_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;

            if (cfg_we)
            begin
                active_reg <= AS_W'(cfg_wdata);
            end

            // accept and clear the scan state
            if (in_accept)
            begin
                func_reg        <= s_axis_tuser;
                handle_reg      <= in_handle;
                zero_reg        <= (in_handle == '0);
                lim_reg         <= lim_next;
                issue_reg       <= '0;
                pending_reg     <= 1'b0;
                hit_reg         <= 1'b0;
                empty_found_reg <= 1'b0;
            end

            // scan: one read issued and one key compared per cycle
            if (state_reg == S_SCAN)
            begin
                pending_reg <= issue_go;
                if (issue_go)
                begin
                    issue_reg    <= issue_reg + LW'(1);
                    pend_idx_reg <= issue_reg[AW-1:0];
                    vld_q_reg    <= valid_reg[issue_reg[AW-1:0]];
                end
                if (match)
                begin
                    hit_reg     <= 1'b1;
                    hit_idx_reg <= pend_idx_reg;
                end
                else if (pending_reg && (key_eff == '0) && !empty_found_reg)
                begin
                    empty_found_reg <= 1'b1;
                    empty_idx_reg   <= pend_idx_reg;
                end
            end

            // write back and form the result
            if (state_reg == S_WRITE)
            begin
                if (ins)
                begin
                    valid_reg[empty_idx_reg] <= 1'b1;
                    count_reg                <= count_reg + LW'(1);
                end
                if (rem)
                begin
                    valid_reg[hit_idx_reg] <= 1'b0;
                    if (count_reg != '0)
                    begin
                        count_reg <= count_reg - LW'(1);
                    end
                end
                priority if (zero_reg)
                begin
                    res_status_reg <= est_pkg::ST_PRESENT;
                    res_slot_reg   <= '0;
                end
                else if (func_reg == est_pkg::OP_ENABLE)
                begin
                    if (hit_reg)
                    begin
                        res_status_reg <= est_pkg::ST_PRESENT;
                        res_slot_reg   <= est_pkg::SLOT_W'(hit_idx_reg);
                    end
                    else if (empty_found_reg)
                    begin
                        res_status_reg <= est_pkg::ST_ADDED;
                        res_slot_reg   <= est_pkg::SLOT_W'(empty_idx_reg);
                    end
                    else
                    begin
                        res_status_reg <= est_pkg::ST_FULL;
                        res_slot_reg   <= '0;
                    end
                end
                else
                begin
                    if (hit_reg)
                    begin
                        res_status_reg <= est_pkg::ST_REMOVED;
                        res_slot_reg   <= est_pkg::SLOT_W'(hit_idx_reg);
                    end
                    else
                    begin
                        res_status_reg <= est_pkg::ST_NOT_FOUND;
                        res_slot_reg   <= '0;
                    end
                end
            end

            // output register
            if ((state_reg == S_OUT) && out_free)
            begin
                out_valid_reg <= 1'b1;
                out_data_reg  <= {{PAD_W{1'b0}},
                                  est_pkg::COUNT_W'(count_reg),
                                  res_slot_reg,
                                  res_status_reg};
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

`ifndef SYNTH
    a_count_matches_valid: assert property (@(posedge clk) disable iff (!rst_n)
        32'(count_reg) == $countones(valid_reg))
        else $error("occupied count differs from valid slots");

    a_one_item_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        in_accept |=> !s_axis_tready)
        else $error("second beat accepted during a lookup");

    a_result_from_out_state: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_axis_tvalid) |-> $past(state_reg) == S_OUT)
        else $error("result raised outside the output state");
`endif

endmodule
